/* hw/rtl/stp_pkg.sv */
// ----------------------------------------------------------------------------
// Stepper trapezoid profile package
// Shared types, register map, action codes and reset values.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int unsigned DT_CAP_US_DEF = 10000;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_STEPS_PER_DEG = 3'd0;
    localparam logic [2:0] REG_ACCEL_RATE    = 3'd1;
    localparam logic [2:0] REG_FLOOR_SPEED   = 3'd2;
    localparam logic [2:0] REG_DEFAULT_SPEED = 3'd3;
    localparam logic [2:0] REG_MIN_INTERVAL  = 3'd4;
    localparam logic [2:0] REG_LIMIT_LOW     = 3'd5;
    localparam logic [2:0] REG_LIMIT_HIGH    = 3'd6;
    localparam logic [2:0] REG_REVERSE_DIR   = 3'd7;

    // Action codes of an input transaction.
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_MOVE   = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;
    localparam logic [1:0] ACT_SETPOS = 2'd3;

    localparam logic [15:0] RST_STEPS_PER_DEG = 16'd100;
    localparam logic [23:0] RST_ACCEL_RATE    = 24'd2560;
    localparam logic [23:0] RST_FLOOR_SPEED   = 24'd128;
    localparam logic [23:0] RST_DEFAULT_SPEED = 24'd512;
    localparam logic [15:0] RST_MIN_INTERVAL  = 16'd50;
    localparam logic [31:0] RST_LIMIT_LOW     = 32'd0;
    localparam logic [31:0] RST_LIMIT_HIGH    = 32'd9000;

    // A division by one million is done as floor((x >> 6) / 15625), using the
    // reciprocal ceil(2^52 / 15625) = 288230376152 split at bit 20. It is exact
    // for every dividend below 2^44.
    localparam logic [63:0] US_RECIP_HI    = 64'd274877;
    localparam logic [63:0] US_RECIP_LO    = 64'd951000;
    // Interval numerator: 1e6 scaled by Q8.
    localparam logic [63:0] INTERVAL_NUMER = 64'd256000000;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        now_us;
        logic signed [31:0] goal_steps;
        logic [23:0]        peak_speed;
    } t_in_item;

    typedef struct packed {
        logic               step_pulse;
        logic               dir_out;
        logic               busy_res;
        logic signed [31:0] position_steps;
        logic [23:0]        speed_now;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_AD,
        ST_MUL_VV,
        ST_MUL_VVS,
        ST_DIV_Q,
        ST_SQRT,
        ST_MUL_ADT,
        ST_MUL_RH,
        ST_MUL_RL,
        ST_MUL_VS,
        ST_DIV_IV,
        ST_DONE
    } t_state;

endpackage

/* hw/rtl/stepper_trapezoid_profile.sv */
// ----------------------------------------------------------------------------
// Stepper trapezoid profile
// Single-axis step generator with a Q16.8 trapezoidal speed profile.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_stall    o_out_data (t_out_item)
// config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// Move, stop, set-position and idle-tick transactions go from the idle state
// straight to the done state. A running tick walks one shared serial
// arithmetic unit through seven multiplies, up to two divides and one square
// root, and the next transaction is not taken until that tick is through.
// Reset is synchronous and restores the register defaults and the axis state.
// While a transaction is in work the input is stalled; a finished result waits
// in the output register, and the next input transaction is taken meanwhile.
//
module stepper_trapezoid_profile #(
    parameter int unsigned P_DT_CAP_US = stp_pkg::DT_CAP_US_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  stp_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output stp_pkg::t_out_item o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import stp_pkg::*;

    localparam logic [31:0] DT_CAP = 32'(P_DT_CAP_US);

    // Configuration registers.
    logic [15:0] r_spd;
    logic [23:0] r_accel;
    logic [23:0] r_floor;
    logic [23:0] r_dflt;
    logic [15:0] r_minint;
    logic [31:0] r_lim_lo;
    logic [31:0] r_lim_hi;
    logic        r_rev;

    // Axis state.
    logic signed [31:0] r_pos, n_pos;
    logic signed [31:0] r_tgt, n_tgt;
    logic               r_moving, n_moving;
    logic [23:0]        r_speed, n_speed;
    logic [23:0]        r_peak, n_peak;
    logic [31:0]        r_last, n_last;
    logic               r_dir, n_dir;

    // Per-transaction working registers.
    t_state      r_state, n_state;
    logic        r_launch, n_launch;
    logic        r_pulse, n_pulse;
    logic        r_positive, n_positive;
    logic [32:0] r_dist, n_dist;
    logic [31:0] r_elapsed, n_elapsed;
    logic [31:0] r_now, n_now;
    logic [63:0] r_num, n_num;
    logic [63:0] r_tmp, n_tmp;
    logic [23:0] r_want, n_want;

    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_data, n_out_data;

    t_alu_req    alu_req;
    logic [63:0] alu_a, alu_b, alu_res;
    logic        alu_done;

    logic              cfg_wr;
    logic              in_acc;
    logic              out_free;
    logic signed [32:0] diff;
    logic signed [31:0] goal_clamped;
    logic [31:0]       dtc;
    logic [63:0]       rsum;
    logic [23:0]       delta;
    logic [24:0]       slew;
    logic [31:0]       iv_raw;
    logic [31:0]       iv;
    logic              step_now;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd    <= RST_STEPS_PER_DEG;
            r_accel  <= RST_ACCEL_RATE;
            r_floor  <= RST_FLOOR_SPEED;
            r_dflt   <= RST_DEFAULT_SPEED;
            r_minint <= RST_MIN_INTERVAL;
            r_lim_lo <= RST_LIMIT_LOW;
            r_lim_hi <= RST_LIMIT_HIGH;
            r_rev    <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_STEPS_PER_DEG: r_spd    <= pwdata[15:0];
                REG_ACCEL_RATE:    r_accel  <= pwdata[23:0];
                REG_FLOOR_SPEED:   r_floor  <= pwdata[23:0];
                REG_DEFAULT_SPEED: r_dflt   <= pwdata[23:0];
                REG_MIN_INTERVAL:  r_minint <= pwdata[15:0];
                REG_LIMIT_LOW:     r_lim_lo <= pwdata;
                REG_LIMIT_HIGH:    r_lim_hi <= pwdata;
                REG_REVERSE_DIR:   r_rev    <= pwdata[0];
                default:           r_rev    <= r_rev;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_STEPS_PER_DEG: prdata = {16'd0, r_spd};
            REG_ACCEL_RATE:    prdata = {8'd0, r_accel};
            REG_FLOOR_SPEED:   prdata = {8'd0, r_floor};
            REG_DEFAULT_SPEED: prdata = {8'd0, r_dflt};
            REG_MIN_INTERVAL:  prdata = {16'd0, r_minint};
            REG_LIMIT_LOW:     prdata = r_lim_lo;
            REG_LIMIT_HIGH:    prdata = r_lim_hi;
            REG_REVERSE_DIR:   prdata = {31'd0, r_rev};
            default:           prdata = '0;
        endcase
    end

    stp_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // Operands follow the current state; the unit latches them on the launch cycle.
    always_comb begin
        alu_req.start = r_launch;
        alu_req.op    = OP_MUL;
        alu_a         = '0;
        alu_b         = '0;
        case (r_state)
            ST_MUL_AD: begin
                alu_a = {40'd0, r_accel};
                alu_b = {31'd0, r_dist};
            end
            ST_MUL_VV: begin
                alu_a = {40'd0, r_speed};
                alu_b = {40'd0, r_speed};
            end
            ST_MUL_VVS: begin
                alu_a = r_tmp;
                alu_b = {48'd0, r_spd};
            end
            ST_DIV_Q: begin
                // 512*A*D fits in 64 bits whenever the move is decelerating.
                alu_req.op = OP_DIV;
                alu_a      = {r_num[54:0], 9'd0};
                alu_b      = {48'd0, r_spd};
            end
            ST_SQRT: begin
                alu_req.op = OP_SQRT;
                alu_a      = r_tmp;
            end
            ST_MUL_ADT: begin
                alu_a = {40'd0, r_accel};
                alu_b = {32'd0, dtc};
            end
            // The speed step A*dt/1e6 is taken from two partial reciprocal
            // products of (A*dt) >> 6.
            ST_MUL_RH: begin
                alu_a = {6'd0, r_tmp[63:6]};
                alu_b = US_RECIP_HI;
            end
            ST_MUL_RL: begin
                alu_a = {6'd0, r_tmp[63:6]};
                alu_b = US_RECIP_LO;
            end
            ST_MUL_VS: begin
                alu_a = {40'd0, r_speed};
                alu_b = {48'd0, r_spd};
            end
            ST_DIV_IV: begin
                alu_req.op = OP_DIV;
                alu_a      = INTERVAL_NUMER;
                alu_b      = r_tmp;
            end
            default: alu_req.op = OP_MUL;
        endcase
    end

    // Helpers for the tick arithmetic.
    always_comb begin
        diff = {r_tgt[31], r_tgt} - {r_pos[31], r_pos};

        goal_clamped = i_in_data.goal_steps;
        if (goal_clamped < $signed(r_lim_lo)) begin
            goal_clamped = $signed(r_lim_lo);
        end
        if (goal_clamped > $signed(r_lim_hi)) begin
            goal_clamped = $signed(r_lim_hi);
        end

        dtc = (r_elapsed > DT_CAP) ? DT_CAP : r_elapsed;

        // High partial product plus the low one shifted down, then the final
        // shift by 32 completes the shift by 52; the quotient fits 24 bits.
        rsum  = r_num + {20'd0, alu_res[63:20]};
        delta = rsum[55:32];

        // Slew toward the wanted speed; the downward step saturates at zero.
        if ({1'b0, r_speed} < {1'b0, r_want}) begin
            slew = {1'b0, r_speed} + {1'b0, delta};
            if (slew > {1'b0, r_want}) begin
                slew = {1'b0, r_want};
            end
        end else if (r_speed > r_want) begin
            slew = (r_speed > delta) ?
                   ({1'b0, r_speed} - {1'b0, delta}) : 25'd0;
            if (slew < {1'b0, r_want}) begin
                slew = {1'b0, r_want};
            end
        end else begin
            slew = {1'b0, r_speed};
        end
        if (slew < {1'b0, r_floor}) begin
            slew = {1'b0, r_floor};
        end

        // A zero speed-steps product saturates the interval.
        iv_raw = (r_state == ST_MUL_VS) ? 32'hFFFF_FFFF : alu_res[31:0];
        iv     = (iv_raw < {16'd0, r_minint}) ? {16'd0, r_minint} : iv_raw;
        step_now = (r_elapsed >= iv);
    end

    always_comb begin
        n_pos       = r_pos;
        n_tgt       = r_tgt;
        n_moving    = r_moving;
        n_speed     = r_speed;
        n_peak      = r_peak;
        n_last      = r_last;
        n_dir       = r_dir;
        n_state     = r_state;
        n_launch    = 1'b0;
        n_pulse     = r_pulse;
        n_positive  = r_positive;
        n_dist      = r_dist;
        n_elapsed   = r_elapsed;
        n_now       = r_now;
        n_num       = r_num;
        n_tmp       = r_tmp;
        n_want      = r_want;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_pulse = 1'b0;
                    n_state = ST_DONE;
                    case (i_in_data.action)
                        ACT_MOVE: begin
                            n_tgt    = goal_clamped;
                            n_peak   = (i_in_data.peak_speed != 24'd0) ?
                                       i_in_data.peak_speed : r_dflt;
                            n_speed  = r_floor;
                            n_moving = 1'b1;
                            n_last   = i_in_data.now_us;
                        end
                        ACT_STOP: begin
                            n_moving = 1'b0;
                            n_speed  = '0;
                            n_tgt    = r_pos;
                        end
                        ACT_SETPOS: begin
                            n_pos = i_in_data.goal_steps;
                            n_tgt = i_in_data.goal_steps;
                        end
                        default: begin
                            if (r_moving) begin
                                if (diff == 33'sd0) begin
                                    // Arrived: the move ends without a step.
                                    n_moving = 1'b0;
                                    n_speed  = '0;
                                end else begin
                                    n_positive = !diff[32];
                                    n_dir      = !diff[32] ^ r_rev;
                                    n_dist     = diff[32] ? 33'(-diff) : 33'(diff);
                                    n_elapsed  = i_in_data.now_us - r_last;
                                    n_now      = i_in_data.now_us;
                                    n_state    = ST_MUL_AD;
                                    n_launch   = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_MUL_AD: begin
                if (alu_done) begin
                    n_num    = alu_res;
                    n_state  = ST_MUL_VV;
                    n_launch = 1'b1;
                end
            end
            ST_MUL_VV: begin
                if (alu_done) begin
                    n_tmp    = alu_res;
                    n_state  = ST_MUL_VVS;
                    n_launch = 1'b1;
                end
            end
            ST_MUL_VVS: begin
                if (alu_done) begin
                    n_launch = 1'b1;
                    if (r_num <= {9'd0, alu_res[63:9]}) begin
                        if (r_spd == 16'd0) begin
                            n_want  = '0;
                            n_state = ST_MUL_ADT;
                        end else begin
                            n_state = ST_DIV_Q;
                        end
                    end else begin
                        n_want  = r_peak;
                        n_state = ST_MUL_ADT;
                    end
                end
            end
            ST_DIV_Q: begin
                if (alu_done) begin
                    n_tmp    = alu_res;
                    n_state  = ST_SQRT;
                    n_launch = 1'b1;
                end
            end
            ST_SQRT: begin
                if (alu_done) begin
                    n_want   = alu_res[23:0];
                    n_state  = ST_MUL_ADT;
                    n_launch = 1'b1;
                end
            end
            ST_MUL_ADT: begin
                if (alu_done) begin
                    n_tmp    = alu_res;
                    n_state  = ST_MUL_RH;
                    n_launch = 1'b1;
                end
            end
            ST_MUL_RH: begin
                if (alu_done) begin
                    n_num    = alu_res;
                    n_state  = ST_MUL_RL;
                    n_launch = 1'b1;
                end
            end
            ST_MUL_RL: begin
                if (alu_done) begin
                    n_speed  = slew[23:0];
                    n_state  = ST_MUL_VS;
                    n_launch = 1'b1;
                end
            end
            ST_MUL_VS, ST_DIV_IV: begin
                if (alu_done) begin
                    if (r_state == ST_MUL_VS && alu_res != 64'd0) begin
                        n_tmp    = alu_res;
                        n_state  = ST_DIV_IV;
                        n_launch = 1'b1;
                    end else begin
                        n_state = ST_DONE;
                        if (step_now) begin
                            n_pos   = r_positive ? (r_pos + 32'sd1) : (r_pos - 32'sd1);
                            n_last  = r_now;
                            n_pulse = 1'b1;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid               = 1'b1;
                    n_out_data.step_pulse     = r_pulse;
                    n_out_data.dir_out        = r_dir;
                    n_out_data.busy_res       = r_moving;
                    n_out_data.position_steps = r_pos;
                    n_out_data.speed_now      = r_speed;
                    n_state                   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_tgt       <= '0;
            r_moving    <= 1'b0;
            r_speed     <= '0;
            r_peak      <= RST_DEFAULT_SPEED;
            r_last      <= '0;
            r_dir       <= 1'b0;
            r_state     <= ST_IDLE;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_tgt       <= n_tgt;
            r_moving    <= n_moving;
            r_speed     <= n_speed;
            r_peak      <= n_peak;
            r_last      <= n_last;
            r_dir       <= n_dir;
            r_state     <= n_state;
            r_launch    <= n_launch;
            r_out_valid <= n_out_valid;
        end
        r_pulse    <= n_pulse;
        r_positive <= n_positive;
        r_dist     <= n_dist;
        r_elapsed  <= n_elapsed;
        r_now      <= n_now;
        r_num      <= n_num;
        r_tmp      <= n_tmp;
        r_want     <= n_want;
        r_out_data <= n_out_data;
    end

    // Every accepted transaction leaves the idle state on the next cycle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("accepted transaction did not start processing");

    // The arithmetic unit only reports completion while an operation is pending.
    a_done_in_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state != ST_IDLE && r_state != ST_DONE))
        else $error("arithmetic completion outside an operation state");

    // A result leaving the done state is presented on the next cycle.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> o_out_valid)
        else $error("finished transaction produced no result");

    // A step is only ever issued while a move is still running.
    a_step_in_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.step_pulse) |-> o_out_data.busy_res)
        else $error("step pulse outside a move");

endmodule

/* hw/rtl/stp_alu.sv */
// ----------------------------------------------------------------------------
// Stepper profile arithmetic unit
// Bit-serial multiply, restoring divide and digit-by-digit square root.
// ----------------------------------------------------------------------------
module stp_alu (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stp_pkg::t_alu_req i_req,
    input  logic [63:0]     i_a,
    input  logic [63:0]     i_b,
    output logic            o_done,
    output logic [63:0]     o_res
);
    import stp_pkg::*;

    localparam logic [6:0] MUL_ITERS  = 7'd40;
    localparam logic [6:0] DIV_ITERS  = 7'd64;
    localparam logic [6:0] SQRT_ITERS = 7'd32;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [6:0]  r_cnt, n_cnt;
    t_alu_op     r_op, n_op;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_x, n_x;
    logic [63:0] r_y, n_y;
    logic [64:0] r_rem, n_rem;

    logic [64:0] div_sh;
    logic [64:0] sq_sh;
    logic [64:0] sq_trial;

    always_comb begin
        div_sh   = {r_rem[63:0], r_x[63]};
        sq_sh    = {r_rem[62:0], r_x[63:62]};
        sq_trial = {1'b0, r_acc[61:0], 2'b01};
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_op     = r_op;
        n_acc    = r_acc;
        n_x      = r_x;
        n_y      = r_y;
        n_rem    = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_x    = i_a;
            n_y    = i_b;
            n_acc  = '0;
            n_rem  = '0;
            case (i_req.op)
                OP_MUL:  n_cnt = MUL_ITERS;
                OP_DIV:  n_cnt = DIV_ITERS;
                OP_SQRT: n_cnt = SQRT_ITERS;
                default: n_cnt = MUL_ITERS;
            endcase
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    if (r_y[0]) begin
                        n_acc = r_acc + r_x;
                    end
                    n_x = {r_x[62:0], 1'b0};
                    n_y = {1'b0, r_y[63:1]};
                end
                OP_DIV: begin
                    n_x = {r_x[62:0], 1'b0};
                    if (div_sh >= {1'b0, r_y}) begin
                        n_rem = div_sh - {1'b0, r_y};
                        n_acc = {r_acc[62:0], 1'b1};
                    end else begin
                        n_rem = div_sh;
                        n_acc = {r_acc[62:0], 1'b0};
                    end
                end
                OP_SQRT: begin
                    n_x = {r_x[61:0], 2'b00};
                    if (sq_sh >= sq_trial) begin
                        n_rem = sq_sh - sq_trial;
                        n_acc = {r_acc[62:0], 1'b1};
                    end else begin
                        n_rem = sq_sh;
                        n_acc = {r_acc[62:0], 1'b0};
                    end
                end
                default: n_busy = 1'b0;
            endcase
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Stepper trapezoid profile testbench
// Drives tick, move, stop and set-position transactions with random gaps and
// output stalls, predicts every result with a cycle-free model of the speed
// profile and compares each output transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import stp_pkg::*;

    localparam int unsigned DT_CAP = DT_CAP_US_DEF;
    localparam longint unsigned CYCLE_LIMIT = 4000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic      psel = 1'b0;
    logic      penable = 1'b0;
    logic      pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copies of the configuration registers.
    logic [15:0] cfg_spd;
    logic [23:0] cfg_accel, cfg_floor, cfg_dflt;
    logic [15:0] cfg_minint;
    logic signed [31:0] cfg_lo, cfg_hi;
    logic        cfg_rev;

    // Shadow copy of the axis state.
    logic signed [31:0] ax_pos, ax_tgt;
    logic        ax_moving, ax_dir;
    logic [23:0] ax_speed, ax_peak;
    logic [31:0] ax_last;

    t_out_item   expected_q[$];
    int unsigned error_count = 0;
    longint unsigned cycle_count = 0;
    logic        stall_enable = 1'b0;

    always #6 i_clk = ~i_clk;

    stepper_trapezoid_profile u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The run ends here if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // One profile update; returns 1 when a step pulse is issued.
    function automatic logic profile_tick(input logic [31:0] now);
        longint signed diff;
        longint unsigned distance, want, elapsed, dtc, delta, v, num, q, prod, ival;
        logic positive;
        if (!ax_moving) return 1'b0;
        diff = longint'(ax_tgt) - longint'(ax_pos);
        if (diff == 0) begin
            ax_moving = 1'b0;
            ax_speed = '0;
            return 1'b0;
        end
        positive = diff > 0;
        ax_dir = positive ^ cfg_rev;
        distance = positive ? diff : -diff;
        v = ax_speed;
        num = cfg_accel * distance;
        if (num <= ((v * v * cfg_spd) >> 9)) begin
            if (cfg_spd == 0) q = 0;
            else q = (num / cfg_spd) * 512 + ((num % cfg_spd) * 512) / cfg_spd;
            want = int_sqrt(q);
        end else begin
            want = ax_peak;
        end
        elapsed = 32'(now - ax_last);
        dtc = elapsed > DT_CAP ? DT_CAP : elapsed;
        delta = (cfg_accel * dtc) / 1000000;
        if (v < want) begin
            v += delta;
            if (v > want) v = want;
        end else if (v > want) begin
            v = v > delta ? v - delta : 0;
            if (v < want) v = want;
        end
        if (v < cfg_floor) v = cfg_floor;
        ax_speed = v[23:0];
        prod = longint'(ax_speed) * cfg_spd;
        ival = prod == 0 ? 64'hFFFF_FFFF : 256000000 / prod;
        if (ival < cfg_minint) ival = cfg_minint;
        if (elapsed >= ival) begin
            ax_pos = positive ? ax_pos + 1 : ax_pos - 1;
            ax_last = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_item predict_item(input t_in_item it);
        t_out_item r;
        longint signed g;
        logic pulse;
        pulse = 1'b0;
        case (it.action)
            ACT_TICK: begin
                pulse = profile_tick(it.now_us);
            end
            ACT_MOVE: begin
                g = it.goal_steps;
                if (g < cfg_lo) g = cfg_lo;
                if (g > cfg_hi) g = cfg_hi;
                ax_tgt = g[31:0];
                ax_peak = it.peak_speed != 0 ? it.peak_speed : cfg_dflt;
                ax_speed = cfg_floor;
                ax_moving = 1'b1;
                ax_last = it.now_us;
            end
            ACT_STOP: begin
                ax_moving = 1'b0;
                ax_speed = '0;
                ax_tgt = ax_pos;
            end
            default: begin
                ax_pos = it.goal_steps;
                ax_tgt = it.goal_steps;
            end
        endcase
        r.step_pulse = pulse;
        r.dir_out = ax_dir;
        r.busy_res = ax_moving;
        r.position_steps = ax_pos;
        r.speed_now = ax_speed;
        return r;
    endfunction

    // Output side: each result is checked against the oldest expectation and,
    // once stalls are enabled, may be followed by a random output stall.
    initial begin : out_checker
        t_out_item exp_item;
        int unsigned hold;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall && i_rst_n) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    exp_item = expected_q.pop_front();
                    if (o_out_data.step_pulse !== exp_item.step_pulse)
                        report_mismatch("step_pulse", o_out_data.step_pulse,
                                        exp_item.step_pulse);
                    if (o_out_data.dir_out !== exp_item.dir_out)
                        report_mismatch("dir_out", o_out_data.dir_out,
                                        exp_item.dir_out);
                    if (o_out_data.busy_res !== exp_item.busy_res)
                        report_mismatch("busy_res", o_out_data.busy_res,
                                        exp_item.busy_res);
                    if (o_out_data.position_steps !== exp_item.position_steps)
                        report_mismatch("position_steps", o_out_data.position_steps,
                                        exp_item.position_steps);
                    if (o_out_data.speed_now !== exp_item.speed_now)
                        report_mismatch("speed_now", o_out_data.speed_now,
                                        exp_item.speed_now);
                end
                hold = stall_enable ? $urandom_range(0, 15) : 0;
                if (hold != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Configuration write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STEPS_PER_DEG: cfg_spd = value[15:0];
            REG_ACCEL_RATE:    cfg_accel = value[23:0];
            REG_FLOOR_SPEED:   cfg_floor = value[23:0];
            REG_DEFAULT_SPEED: cfg_dflt = value[23:0];
            REG_MIN_INTERVAL:  cfg_minint = value[15:0];
            REG_LIMIT_LOW:     cfg_lo = value;
            REG_LIMIT_HIGH:    cfg_hi = value;
            default:           cfg_rev = value[0];
        endcase
    endtask

    // Send a transaction after a gap, random once stalls are on; the expectation
    // is queued at acceptance. Valid stays high until the next gap or drain.
    task automatic send_item(input logic [1:0] act, input logic [31:0] now,
                             input logic [31:0] goal, input logic [23:0] pk);
        t_in_item it;
        int unsigned gap;
        it.action = act;
        it.now_us = now;
        it.goal_steps = goal;
        it.peak_speed = pk;
        gap = stall_enable ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(predict_item(it));
    endtask

    // Waits until every result has come back, then lets the block settle.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    logic [31:0] clock_us = 0;

    // Advances the microsecond timestamp by a random step, mostly small.
    function automatic logic [31:0] next_time();
        case ($urandom_range(0, 9))
            0:       clock_us += $urandom_range(10000, 100000);
            1:       clock_us += $urandom;
            default: clock_us += $urandom_range(0, 3000);
        endcase
        return clock_us;
    endfunction

    // Extreme fields, every action, limits crossed, set position while running,
    // idle ticks and a time wrap.
    task automatic test_directed;
        send_item(ACT_TICK, 32'd5, 32'd0, 24'd0);
        send_item(ACT_MOVE, 32'd0, 32'h7FFF_FFFF, 24'hFF_FFFF);
        send_item(ACT_TICK, 32'd100, 32'd0, 24'd0);
        send_item(ACT_TICK, 32'd20000, 32'd0, 24'd0);
        send_item(ACT_STOP, 32'd20001, 32'd0, 24'd0);
        send_item(ACT_MOVE, 32'hFFFF_FF00, 32'h8000_0000, 24'd0);
        send_item(ACT_SETPOS, 32'hFFFF_FFFF, 32'd40, 24'hFF_FFFF);
        send_item(ACT_TICK, 32'd300, 32'd0, 24'd0);
        send_item(ACT_SETPOS, 32'd0, 32'hFFFF_FFFF, 24'd0);
        send_item(ACT_MOVE, 32'd1000, 32'd3, 24'd1);
        for (int k = 0; k < 8; k++) send_item(ACT_TICK, 32'd1000 + 30000 * (k + 1),
                                               32'hFFFF_FFFF, 24'd0);
        send_item(ACT_TICK, 32'hFFFF_FFFF, 32'h5555_AAAA, 24'hAA_5555);
        drain();
        clock_us = 32'd400000;
    endtask

    // Mostly complete moves: a move followed by a run of ticks, with stray
    // stops and position loads mixed in.
    task automatic test_random_moves(input int unsigned n_items);
        int unsigned sent, run;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0: send_item(ACT_STOP, next_time(), $urandom, 24'($urandom));
                1: send_item(ACT_SETPOS, next_time(),
                             cfg_lo + $signed($urandom_range(0, 200)), 24'($urandom));
                2: send_item(ACT_SETPOS, next_time(), $urandom, 24'($urandom));
                3: send_item(ACT_MOVE, next_time(), $urandom,
                             $urandom_range(0, 1) ? 24'd0 : 24'($urandom));
                default: begin
                    send_item(ACT_MOVE, next_time(),
                              ax_pos + $signed($urandom_range(0, 60)) - 30,
                              $urandom_range(0, 2) == 0 ? 24'd0
                                                        : 24'($urandom_range(1, 8192)));
                end
            endcase
            sent++;
            run = $urandom_range(1, 40);
            for (int k = 0; k < run && sent < n_items; k++) begin
                send_item(ACT_TICK, next_time(), $urandom, 24'($urandom));
                sent++;
            end
        end
        drain();
    endtask

    initial begin : main_sequence
        cfg_spd = RST_STEPS_PER_DEG; cfg_accel = RST_ACCEL_RATE;
        cfg_floor = RST_FLOOR_SPEED; cfg_dflt = RST_DEFAULT_SPEED;
        cfg_minint = RST_MIN_INTERVAL; cfg_lo = RST_LIMIT_LOW;
        cfg_hi = RST_LIMIT_HIGH; cfg_rev = 1'b0;
        ax_pos = 0; ax_tgt = 0; ax_moving = 0; ax_dir = 0;
        ax_speed = 0; ax_peak = RST_DEFAULT_SPEED; ax_last = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        stall_enable = 1'b1;

        // Reset settings, wide limits so moves can go anywhere.
        write_reg(REG_LIMIT_LOW, 32'h8000_0000);
        write_reg(REG_LIMIT_HIGH, 32'h7FFF_FFFF);
        test_random_moves(300);

        // Crossed limits, reversed direction and extreme rates.
        write_reg(REG_LIMIT_LOW, 32'd50);
        write_reg(REG_LIMIT_HIGH, 32'd20);
        write_reg(REG_REVERSE_DIR, 32'd1);
        write_reg(REG_ACCEL_RATE, 32'hFF_FFFF);
        write_reg(REG_STEPS_PER_DEG, 32'd1);
        write_reg(REG_MIN_INTERVAL, 32'd1);
        send_item(ACT_MOVE, next_time(), 32'd0, 24'd0);
        test_random_moves(250);

        write_reg(REG_STEPS_PER_DEG, 32'hFFFF);
        write_reg(REG_FLOOR_SPEED, 32'hFF_FFFF);
        write_reg(REG_DEFAULT_SPEED, 32'hFF_FFFF);
        write_reg(REG_MIN_INTERVAL, 32'hFFFF);
        write_reg(REG_LIMIT_LOW, 32'hFFFF_FF00);
        write_reg(REG_LIMIT_HIGH, 32'd256);
        test_random_moves(250);

        write_reg(REG_STEPS_PER_DEG, 32'd0);
        write_reg(REG_ACCEL_RATE, 32'd1);
        write_reg(REG_FLOOR_SPEED, 32'd1);
        write_reg(REG_DEFAULT_SPEED, 32'd1);
        test_random_moves(150);

        write_reg(REG_STEPS_PER_DEG, 32'd16);
        write_reg(REG_ACCEL_RATE, 32'd40000);
        write_reg(REG_FLOOR_SPEED, 32'd256);
        write_reg(REG_DEFAULT_SPEED, 32'd20000);
        write_reg(REG_MIN_INTERVAL, 32'd20);
        write_reg(REG_REVERSE_DIR, 32'd0);
        test_random_moves(350);

        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/stp_pkg.sv
hw/rtl/stp_alu.sv
hw/rtl/stepper_trapezoid_profile.sv
tb/testbench.sv
